FILE: hw/rtl/rcl_pkg.sv
// Shared types and constants for the rotary combination lock core.
// No dependencies; imported by every module of the block.
package rcl_pkg;

    localparam int MAX_DIGITS  = 8;
    localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
    localparam int CNT_W       = 4;

    localparam logic [3:0] DIGIT_MAX = 4'd9;
    localparam logic [7:0] FAIL_MAX  = 8'd255;

    typedef enum logic [1:0] {
        MODE_ENTERING = 2'd0,
        MODE_OPEN     = 2'd1,
        MODE_LOCKED   = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_STARTED = 3'd1,
        EV_CHANGED = 3'd2,
        EV_OK      = 3'd3,
        EV_WRONG   = 3'd4,
        EV_LOCKOUT = 3'd5,
        EV_RESET   = 3'd6,
        EV_CLOSED  = 3'd7
    } event_t;

    typedef enum logic [1:0] {
        REG_CODE_DIGITS   = 2'd0,
        REG_CODE_LENGTH   = 2'd1,
        REG_ATTEMPT_LIMIT = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic              req_type;
        logic signed [1:0] turn_direction;
    } item_t;

    typedef struct packed {
        event_t          event_code;
        mode_t           lock_mode;
        logic [3:0]      digit_shown;
        logic [CNT_W-1:0] digits_done;
        logic [7:0]      attempts_spent;
    } result_t;

endpackage

FILE: hw/rtl/rcl_in_reg.sv
// Input register of the rotary combination lock core.
// Depends on rcl_pkg for the item type.
module rcl_in_reg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  rcl_pkg::item_t in_item,
    input  logic          advance,
    output logic          held_valid,
    output rcl_pkg::item_t held_item
);
    import rcl_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Free when empty, or when the held item moves on this cycle.
    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

FILE: hw/rtl/rcl_engine.sv
// Lock state, configuration registers and next-state logic of the lock core.
// Depends on rcl_pkg for types and constants.
module rcl_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  rcl_pkg::reg_index_t cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                advance,
    input  rcl_pkg::item_t      item,
    output rcl_pkg::result_t    result
);
    import rcl_pkg::*;

    typedef logic [MAX_DIGITS-1:0][3:0] store_t;

    // configuration
    logic [31:0]      code_digits_reg, code_digits_next;
    logic [CNT_W-1:0] code_length_reg, code_length_next;
    logic [7:0]       attempt_limit_reg, attempt_limit_next;
    logic             cfg_ok_reg, cfg_ok_next;
    logic             cfg_hit;

    // lock state
    mode_t            mode_reg, mode_next;
    store_t           store_reg, store_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [3:0]       digit_reg, digit_next;
    logic             active_reg, active_next;
    logic             dir_reg, dir_next;
    logic [7:0]       fail_reg, fail_next;

    logic             tick_neg;
    logic [7:0]       fail_inc;
    logic [CNT_W-1:0] total_inc;
    store_t           store_conf;
    logic             mismatch;
    logic             spend;
    logic             wipe;
    event_t           spend_ev;
    event_t           ev;

    // Register write decode and validity check of the new setup.
    always_comb begin
        code_digits_next   = code_digits_reg;
        code_length_next   = code_length_reg;
        attempt_limit_next = attempt_limit_reg;
        cfg_hit            = 1'b1;
        case (cfg_index)
            REG_CODE_DIGITS:   code_digits_next   = cfg_data;
            REG_CODE_LENGTH:   code_length_next   = cfg_data[CNT_W-1:0];
            REG_ATTEMPT_LIMIT: attempt_limit_next = cfg_data[7:0];
            default:           cfg_hit            = 1'b0;
        endcase
        cfg_ok_next = (code_length_next != '0)
                   && (code_length_next <= CNT_W'(MAX_DIGITS))
                   && (attempt_limit_next != 8'd0);
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (CNT_W'(i) < code_length_next && code_digits_next[4*i +: 4] > DIGIT_MAX) begin
                cfg_ok_next = 1'b0;
            end
        end
    end

    // Confirmed-digit view of the store and the code compare.
    always_comb begin
        total_inc  = total_reg + CNT_W'(1);
        store_conf = store_reg;
        if (total_reg < CNT_W'(MAX_DIGITS)) begin
            store_conf[total_reg[DIGIT_IDX_W-1:0]] = digit_reg;
        end
        mismatch = 1'b0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (CNT_W'(i) < code_length_reg && store_conf[i] != code_digits_reg[4*i +: 4]) begin
                mismatch = 1'b1;
            end
        end
        fail_inc = (fail_reg != FAIL_MAX) ? fail_reg + 8'd1 : fail_reg;
        tick_neg = (item.turn_direction != 2'sd1);
    end

    // Next state for the item in the input register.
    always_comb begin
        mode_next   = mode_reg;
        store_next  = store_reg;
        total_next  = total_reg;
        digit_next  = digit_reg;
        active_next = active_reg;
        dir_next    = dir_reg;
        fail_next   = fail_reg;
        ev          = EV_NONE;
        spend       = 1'b0;
        spend_ev    = EV_NONE;
        wipe        = 1'b0;
        if (cfg_ok_reg) begin
            if (item.req_type) begin
                case (mode_reg)
                    MODE_ENTERING: begin
                        spend    = 1'b1;
                        spend_ev = EV_RESET;
                    end
                    MODE_OPEN: begin
                        mode_next = MODE_ENTERING;
                        wipe      = 1'b1;
                        ev        = EV_CLOSED;
                    end
                    default: ;
                endcase
            end else if (mode_reg == MODE_ENTERING && item.turn_direction != 2'sd0) begin
                if (active_reg && tick_neg == dir_reg) begin
                    digit_next = (digit_reg == DIGIT_MAX) ? 4'd0 : digit_reg + 4'd1;
                    ev         = EV_CHANGED;
                end else if (active_reg && total_inc >= code_length_reg) begin
                    if (!mismatch) begin
                        mode_next = MODE_OPEN;
                        fail_next = 8'd0;
                        wipe      = 1'b1;
                        ev        = EV_OK;
                    end else begin
                        spend    = 1'b1;
                        spend_ev = EV_WRONG;
                    end
                end else begin
                    if (active_reg) begin
                        store_next = store_conf;
                        total_next = total_inc;
                    end
                    digit_next  = 4'd0;
                    active_next = 1'b1;
                    dir_next    = tick_neg;
                    ev          = EV_STARTED;
                end
            end
        end
        if (spend) begin
            fail_next = fail_inc;
            wipe      = 1'b1;
            if (fail_inc >= attempt_limit_reg) begin
                mode_next = MODE_LOCKED;
                ev        = EV_LOCKOUT;
            end else begin
                ev = spend_ev;
            end
        end
        if (wipe) begin
            store_next  = '0;
            total_next  = '0;
            digit_next  = 4'd0;
            active_next = 1'b0;
            dir_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_digits_reg   <= 32'd0;
            code_length_reg   <= CNT_W'(4);
            attempt_limit_reg <= 8'd3;
            cfg_ok_reg        <= 1'b1;
            mode_reg          <= MODE_ENTERING;
            store_reg         <= '0;
            total_reg         <= '0;
            digit_reg         <= 4'd0;
            active_reg        <= 1'b0;
            dir_reg           <= 1'b0;
            fail_reg          <= 8'd0;
        end else if (cfg_we && cfg_hit) begin
            // any register write restarts the lock
            code_digits_reg   <= code_digits_next;
            code_length_reg   <= code_length_next;
            attempt_limit_reg <= attempt_limit_next;
            cfg_ok_reg        <= cfg_ok_next;
            mode_reg          <= MODE_ENTERING;
            store_reg         <= '0;
            total_reg         <= '0;
            digit_reg         <= 4'd0;
            active_reg        <= 1'b0;
            dir_reg           <= 1'b0;
            fail_reg          <= 8'd0;
        end else if (advance) begin
            mode_reg   <= mode_next;
            store_reg  <= store_next;
            total_reg  <= total_next;
            digit_reg  <= digit_next;
            active_reg <= active_next;
            dir_reg    <= dir_next;
            fail_reg   <= fail_next;
        end
    end

    assign result.event_code     = ev;
    assign result.lock_mode      = mode_next;
    assign result.digit_shown    = digit_next;
    assign result.digits_done    = total_next;
    assign result.attempts_spent = fail_next;

endmodule

FILE: hw/rtl/rcl_out_reg.sv
// Result register of the rotary combination lock core.
// Depends on rcl_pkg for the result type.
module rcl_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  rcl_pkg::result_t load_result,
    output logic             out_valid,
    input  logic             out_ready,
    output rcl_pkg::result_t out_result
);
    import rcl_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // Hold the result until taken; a load may replace one taken this cycle.
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

FILE: hw/rtl/rotary_combination_lock_core.sv
// Rotary combination lock core: top level.
// Depends on rcl_pkg, rcl_in_reg, rcl_engine and rcl_out_reg.
//
// Usage:
//  - Input channel (s_*): one item per encoder tick or button press.
//    s_tuser[0] is req_type (0 tick, 1 button); s_tdata[1:0] is the signed
//    turn direction (+1 clockwise, negative counter-clockwise, 0 ignored).
//  - Result channel (m_*): exactly one item per input item, in order.
//    m_tuser holds the event code; m_tdata holds the lock state after the
//    item: mode, digit being dialed, confirmed digit count, spent attempts.
//  - Config channel (cfg_*): index 0 code digits (BCD nibbles), 1 code
//    length, 2 attempt limit. Any write to a listed register restarts the
//    lock; write only while no item is in flight. Always ready.
//  - Path: the input register, then one pass of next-state logic, then the
//    result register, which holds the result until it is taken.
//  - Throughput: one item per cycle while m_tready stays high.
//  - Reset (aresetn low, synchronous): both registers empty, code 0,
//    length 4, limit 3, lock entering with no digits.
//  - Stall: when m_tready is low the result holds; the input register still
//    takes one item, then s_tready drops until the result is taken.
module rotary_combination_lock_core (
    input  logic                aclk,
    input  logic                aresetn,
    // input items
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [1:0] turn_direction, rest zero
    input  logic [0:0]          s_tuser,   // [0] req_type
    // result items
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,   // [1:0] lock_mode, [5:2] digit_shown,
                                           // [9:6] digits_done,
                                           // [17:10] attempts_spent, rest zero
    output logic [2:0]          m_tuser,   // [2:0] event_code
    // configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  rcl_pkg::reg_index_t cfg_index,
    input  logic [31:0]         cfg_data
);
    import rcl_pkg::*;

    item_t   in_item;
    item_t   held_item;
    logic    held_valid;
    logic    out_valid;
    logic    advance;
    result_t step_result;
    result_t out_result;

    assign in_item.req_type       = s_tuser[0];
    assign in_item.turn_direction = s_tdata[1:0];

    // Move the held item through the logic when the result register is free.
    assign advance   = held_valid && (!out_valid || m_tready);
    assign cfg_ready = 1'b1;

    rcl_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    rcl_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .item      (held_item),
        .result    (step_result)
    );

    rcl_out_reg u_out_reg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (advance),
        .load_result (step_result),
        .out_valid   (out_valid),
        .out_ready   (m_tready),
        .out_result  (out_result)
    );

    assign m_tvalid = out_valid;
    assign m_tuser  = out_result.event_code;
    assign m_tdata  = {6'd0,
                       out_result.attempts_spent,
                       out_result.digits_done,
                       out_result.digit_shown,
                       out_result.lock_mode};

endmodule
